[rtl/assert_macros.svh]
// Assertion macros shared by the modular exponentiation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/modexp_pkg.sv]
// Types and constants shared by the modular exponentiation block.
`default_nettype none

package modexp_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_W = $clog2(WORD_BITS);
	localparam logic [WORD_BITS-1:0] MODULUS_RESET = WORD_BITS'(1000000007);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Input item
	typedef struct packed {
		word_t base;
		word_t exponent;
	} modexp_arg_t;

	// Result item
	typedef struct packed {
		word_t power;
		logic  zero_modulus;
	} modexp_res_t;

	// Request to the modular multiplier
	typedef struct packed {
		logic  start;
		word_t a;
		word_t b;
	} mul_req_t;

	// Response from the modular multiplier
	typedef struct packed {
		logic  done;
		word_t prod;
	} mul_rsp_t;

endpackage

`default_nettype wire

[rtl/modexp_mul.sv]
// Bit-serial modular multiplier: one bit of the multiplier per cycle.
`default_nettype none

`include "assert_macros.svh"

module modexp_mul (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire modexp_pkg::word_t   m,
	input  wire modexp_pkg::mul_req_t req,
	output modexp_pkg::mul_rsp_t     rsp
);
	import modexp_pkg::*;

	localparam int T_W = WORD_BITS + 2;

	typedef enum logic {
		M_IDLE,
		M_RUN
	} mul_state_t;

	mul_state_t state_q;
	word_t      r_q;
	word_t      a_q;
	word_t      b_q;
	cnt_t       cnt_q;
	mul_rsp_t   rsp_q;

	logic [T_W-1:0] t;
	logic [T_W-1:0] m1;
	logic [T_W-1:0] m2;
	logic [T_W-1:0] d;
	word_t          r_next;

	// Form 2r + a*bit, which stays below 3m, then fold it back below m
	always_comb begin
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		t  = {1'b0, r_q, 1'b0} + {2'b00, (b_q[WORD_BITS-1] ? a_q : '0)};
		if (t >= m2) begin
			d = t - m2;
		end else if (t >= m1) begin
			d = t - m1;
		end else begin
			d = t;
		end
		r_next = d[WORD_BITS-1:0];
	end

	// Sequence the multiplier bits, most significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= M_IDLE;
			rsp_q.done <= 1'b0;
		end else begin
			rsp_q.done <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_q     <= req.a;
						b_q     <= req.b;
						r_q     <= '0;
						cnt_q   <= CNT_W'(WORD_BITS - 1);
						state_q <= M_RUN;
					end
				end
				M_RUN: begin
					r_q   <= r_next;
					b_q   <= b_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						rsp_q.prod <= r_next;
						rsp_q.done <= 1'b1;
						state_q    <= M_IDLE;
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign rsp = rsp_q;

	`ASSERT_NEXT(a_done_pulse, rsp_q.done, !rsp_q.done, "multiplier done held over two cycles")
	`ASSERT_IMPLIES(a_prod_reduced, rsp_q.done && (m != '0), rsp_q.prod < m, "product not reduced")
	`ASSERT_IMPLIES(a_start_idle, req.start, state_q == M_IDLE, "multiplier started while busy")

endmodule

`default_nettype wire

[rtl/modular_exponentiation_top.sv]
// Top level of the modular exponentiation block: sequencer, modulus register, result register.
//
// Computes base^exponent mod modulus by left-to-right square-and-multiply on one shared
// bit-serial modular multiplier, which retires one multiplier bit per cycle. An item first
// reduces the base (one product), then drops the leading zero bits of the exponent, then
// squares once per exponent bit from the highest set bit down and multiplies once per set
// bit. A zero exponent (result 1) or a zero modulus (result 0 with zero_modulus set) skips
// the multiplier and goes straight to the S_FIN state, which loads the result into the
// output register once that register is free. The block takes one item at a time; a
// finished result waits in the output register and the next item may be accepted while it
// does. Write the modulus only while the block is idle; it resets to 1000000007.
`default_nettype none

`include "assert_macros.svh"

module modular_exponentiation_top (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   arg_valid,
	output logic                        arg_ready,
	input  wire modexp_pkg::modexp_arg_t arg,
	output logic                        res_valid,
	input  wire logic                   res_ready,
	output modexp_pkg::modexp_res_t     res,
	input  wire logic                   cfg_we,
	input  wire modexp_pkg::word_t      cfg_wdata
);
	import modexp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_SKIP,
		S_SQR,
		S_MUL,
		S_FIN
	} seq_state_t;

	seq_state_t  state_q;
	word_t       modulus_q;
	word_t       e_q;
	cnt_t        cnt_q;
	word_t       bred_q;
	modexp_res_t fin_q;
	modexp_res_t res_q;
	logic        res_valid_q;
	mul_req_t    req_q;
	mul_rsp_t    rsp;

	word_t one_m;
	logic  last_bit;
	logic  arg_fire;

	// 1 mod m, which is 0 for a modulus of one
	assign one_m    = (modulus_q == word_t'(1)) ? '0 : word_t'(1);
	assign last_bit = (cnt_q == '0);
	assign arg_fire = arg_valid && arg_ready;

	// Hold the modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	modexp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.m      (modulus_q),
		.req    (req_q),
		.rsp    (rsp)
	);

	// Walk the exponent bits and issue products to the shared multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			req_q.start <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (arg_fire) begin
						e_q   <= arg.exponent;
						cnt_q <= CNT_W'(WORD_BITS - 1);
						if (modulus_q == '0) begin
							fin_q   <= '{power: '0, zero_modulus: 1'b1};
							state_q <= S_FIN;
						end else if (arg.exponent == '0) begin
							fin_q   <= '{power: word_t'(1), zero_modulus: 1'b0};
							state_q <= S_FIN;
						end else begin
							req_q   <= '{start: 1'b1, a: one_m, b: arg.base};
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					if (rsp.done) begin
						bred_q  <= rsp.prod;
						state_q <= S_SKIP;
					end
				end
				S_SKIP: begin
					// Drop leading zero bits: squaring 1 leaves it unchanged
					if (e_q[WORD_BITS-1]) begin
						req_q   <= '{start: 1'b1, a: one_m, b: one_m};
						state_q <= S_SQR;
					end else begin
						e_q   <= e_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SQR: begin
					if (rsp.done) begin
						if (e_q[WORD_BITS-1]) begin
							req_q   <= '{start: 1'b1, a: rsp.prod, b: bred_q};
							state_q <= S_MUL;
						end else if (last_bit) begin
							fin_q   <= '{power: rsp.prod, zero_modulus: 1'b0};
							state_q <= S_FIN;
						end else begin
							e_q     <= e_q << 1;
							cnt_q   <= cnt_q - 1'b1;
							req_q   <= '{start: 1'b1, a: rsp.prod, b: rsp.prod};
						end
					end
				end
				S_MUL: begin
					if (rsp.done) begin
						if (last_bit) begin
							fin_q   <= '{power: rsp.prod, zero_modulus: 1'b0};
							state_q <= S_FIN;
						end else begin
							e_q     <= e_q << 1;
							cnt_q   <= cnt_q - 1'b1;
							req_q   <= '{start: 1'b1, a: rsp.prod, b: rsp.prod};
							state_q <= S_SQR;
						end
					end
				end
				S_FIN: begin
					// Load the result once the output register is free
					if (!res_valid_q || res_ready) begin
						res_q       <= fin_q;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign arg_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	`ASSERT_NEXT(a_busy_after_accept, arg_fire, !arg_ready, "item accepted while busy")
	`ASSERT_IMPLIES(a_zero_mod_power, res_valid_q && res_q.zero_modulus, res_q.power == '0,
		"zero modulus result carries a power")
	`ASSERT_IMPLIES(a_start_state, req_q.start,
		(state_q == S_RED) || (state_q == S_SQR) || (state_q == S_MUL),
		"product issued outside a product state")

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the modular exponentiation block, with a result scoreboard.

import modexp_pkg::*;

// Predict each power from accepted items and compare against returned results
class power_scoreboard;
	typedef logic [2*WORD_BITS-1:0] dword_t;

	word_t       cur_modulus;
	modexp_res_t pending_powers[$];
	int          mismatches;

	function new();
		cur_modulus = MODULUS_RESET;
		mismatches  = 0;
	endfunction

	function int pending_count();
		return pending_powers.size();
	endfunction

	// Square-and-multiply from the top exponent bit, each product at double width
	function modexp_res_t calc_power(word_t b, word_t e);
		modexp_res_t r;
		word_t       acc;
		word_t       b_red;
		dword_t      m;
		m = dword_t'(cur_modulus);
		r.power = '0;
		r.zero_modulus = 1'b0;
		if (cur_modulus == '0) begin
			r.zero_modulus = 1'b1;
			return r;
		end
		// zero exponent gives 1 even when the modulus is 1
		if (e == '0) begin
			r.power = word_t'(1);
			return r;
		end
		b_red = word_t'(dword_t'(b) % m);
		acc = word_t'(dword_t'(1) % m);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			acc = word_t'((dword_t'(acc) * dword_t'(acc)) % m);
			if (e[i])
				acc = word_t'((dword_t'(acc) * dword_t'(b_red)) % m);
		end
		r.power = acc;
		return r;
	endfunction

	function void note_arg(modexp_arg_t a);
		pending_powers.push_back(calc_power(a.base, a.exponent));
	endfunction

	function void check_res(modexp_res_t got);
		modexp_res_t want;
		if (pending_powers.size() == 0) begin
			$display("%0t unexpected result: power %h zero_modulus %b",
				$time, got.power, got.zero_modulus);
			mismatches++;
			return;
		end
		want = pending_powers.pop_front();
		if (got.power !== want.power) begin
			$display("%0t power mismatch: expected %h actual %h",
				$time, want.power, got.power);
			mismatches++;
		end
		if (got.zero_modulus !== want.zero_modulus) begin
			$display("%0t zero_modulus mismatch: expected %b actual %b",
				$time, want.zero_modulus, got.zero_modulus);
			mismatches++;
		end
	endfunction
endclass

module testbench;
	localparam int NUM_RANDOM = 1830;

	logic            clk;
	logic            arst_n;
	logic            arg_valid;
	logic            arg_ready;
	modexp_arg_t     arg;
	logic            res_valid;
	logic            res_ready;
	modexp_res_t     res;
	logic            cfg_we;
	word_t           cfg_wdata;

	power_scoreboard sb;
	bit              steady;

	modular_exponentiation_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.arg_valid (arg_valid),
		.arg_ready (arg_ready),
		.arg       (arg),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Clock: period 2
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Drop ready at random unless in the steady stretch
	always @(negedge clk) begin
		res_ready = steady || ($urandom_range(0, 99) >= 17);
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_ready === 1'b1)
			sb.check_res(res);
	end

	// Present one item, idling first at random, and hold it until accepted
	task automatic send_arg(input word_t b, input word_t e);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 17) begin
			arg_valid = 1'b0;
			@(negedge clk);
		end
		arg_valid    = 1'b1;
		arg.base     = b;
		arg.exponent = e;
		@(posedge clk);
		while (arg_ready !== 1'b1)
			@(posedge clk);
		sb.note_arg(arg);
	endtask

	// Drain the block, then write the modulus
	task automatic write_modulus(input word_t m);
		@(negedge clk);
		arg_valid = 1'b0;
		while (sb.pending_count() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.cur_modulus = m;
	endtask

	function automatic word_t pick_base();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return word_t'($urandom_range(0, 15));
			default: return word_t'($urandom);
		endcase
	endfunction

	// Keep most exponents short; a few span the full word
	function automatic word_t pick_exponent();
		int r;
		int nbits;
		r = $urandom_range(0, 99);
		if (r < 6)
			return word_t'($urandom);
		if (r < 10)
			return '0;
		if (r < 12)
			return '1;
		if (r < 14)
			return word_t'(1) << (WORD_BITS - 1);
		nbits = $urandom_range(1, 10);
		return word_t'($urandom) & ((word_t'(1) << nbits) - 1);
	endfunction

	function automatic word_t pick_modulus(int phase);
		word_t corner[8];
		corner = '{'0, word_t'(1), word_t'(2), '1, word_t'(1) << (WORD_BITS - 1),
			'1 - 1, word_t'(3), MODULUS_RESET};
		if (phase < 8)
			return corner[phase];
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2, 3: return word_t'($urandom_range(1, 1000));
			default: return word_t'($urandom);
		endcase
	endfunction

	initial begin
		#60_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int sent;
		int chunk;
		int phase;
		sb        = new();
		steady    = 1'b0;
		arst_n    = 1'b0;
		arg_valid = 1'b0;
		arg       = '0;
		res_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset modulus, field extremes
		send_arg('0, '0);
		send_arg('0, word_t'(1));
		send_arg('1, '0);
		send_arg('1, word_t'(1));
		send_arg('1, '1);
		send_arg(word_t'(1), '1);
		send_arg(word_t'(2), word_t'(31));
		send_arg(word_t'(2), word_t'(32));
		send_arg(word_t'(3), word_t'(1) << (WORD_BITS - 1));
		send_arg(MODULUS_RESET, word_t'(5));
		send_arg(MODULUS_RESET + 1, word_t'(3));
		send_arg('0, '1);

		// Directed: modulus of one, zero exponent stays unreduced
		write_modulus(word_t'(1));
		send_arg(word_t'(5), '0);
		send_arg(word_t'(5), word_t'(3));
		send_arg('1, '1);

		// Directed: zero modulus flags an error
		write_modulus('0);
		send_arg(word_t'(7), '0);
		send_arg('1, '1);
		send_arg('0, '0);

		// Directed: largest modulus
		write_modulus('1);
		send_arg('1 - 1, word_t'(2));
		send_arg('1, word_t'(7));
		send_arg('1 - 1, '1);

		// Random phases, each under its own modulus
		sent  = 0;
		phase = 0;
		while (sent < NUM_RANDOM) begin
			write_modulus(pick_modulus(phase));
			chunk = $urandom_range(60, 140);
			for (int i = 0; i < chunk && sent < NUM_RANDOM; i++) begin
				steady = (sent >= 700 && sent < 1000);
				send_arg(pick_base(), pick_exponent());
				sent++;
			end
			phase++;
		end
		steady = 1'b0;

		// Drain and settle
		@(negedge clk);
		arg_valid = 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_count() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

[modular_exponentiation_top.f]
+incdir+rtl
rtl/modexp_pkg.sv
rtl/modexp_mul.sv
rtl/modular_exponentiation_top.sv
verif/testbench.sv
